// ===== sv/mor_pkg.sv =====
// Shared types, constants and codes of the median outlier rejection filter.
package mor_pkg;

	localparam int WINDOW   = 5;
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int MED_IDX  = WINDOW / 2;
	localparam int NEED_LE  = MED_IDX + 1;
	localparam int NEED_GE  = WINDOW - MED_IDX;

	localparam int SAMPLE_W = 32;
	localparam int THRESH_W = 31;
	localparam int WIDE_W   = SAMPLE_W + 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [THRESH_W-1:0]        thresh_t;
	typedef logic signed [WIDE_W-1:0]   wide_t;

	localparam sample_t SENT_ZERO = 32'sd0;
	localparam sample_t SENT_ONE  = 32'sd65536;
	localparam sample_t SENT_TWO  = 32'sd131072;

	localparam thresh_t THRESH_RESET = 31'd655360;

	typedef enum logic [0:0] {
		CFG_FILTER_ENABLE    = 1'b0,
		CFG_REJECT_THRESHOLD = 1'b1
	} cfg_index_t;

	// Verdict on one sample, from the judge to the window and output stage.
	typedef struct packed {
		logic rejected;
		logic store;
	} verdict_t;

endpackage

// ===== sv/mor_window.sv =====
// Ring of the most recent samples with its write slot.
module mor_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  mor_pkg::sample_t  wr_data,
	output mor_pkg::sample_t  win [mor_pkg::WINDOW]
);

	mor_pkg::sample_t                win_q [mor_pkg::WINDOW];
	logic [mor_pkg::SLOT_W-1:0]      slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < mor_pkg::WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (wr_en) begin
			win_q[slot_q] <= wr_data;
			if (slot_q == mor_pkg::SLOT_W'(mor_pkg::WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign win = win_q;

	// The slot never points past the last ring entry.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= mor_pkg::SLOT_W'(mor_pkg::WINDOW - 1))
		else $error("window slot out of range");

endmodule

// ===== sv/mor_judge.sv =====
// Rank test of a sample against the window median, and the sentinel check.
module mor_judge (
	input  mor_pkg::sample_t  sample,
	input  mor_pkg::sample_t  win [mor_pkg::WINDOW],
	input  logic              filter_enable,
	input  mor_pkg::thresh_t  reject_threshold,
	output mor_pkg::verdict_t verdict
);

	// The median lies at or below hi exactly when at least NEED_LE entries do,
	// and at or above lo exactly when at least NEED_GE entries do.
	mor_pkg::wide_t             hi;
	mor_pkg::wide_t             lo;
	logic [mor_pkg::WINDOW-1:0] le;
	logic [mor_pkg::WINDOW-1:0] ge;
	logic [mor_pkg::CNT_W-1:0]  cnt_le;
	logic [mor_pkg::CNT_W-1:0]  cnt_ge;
	logic                       inside_band;
	logic                       sentinel;

	always_comb begin
		hi = mor_pkg::wide_t'(sample) + mor_pkg::wide_t'({3'b000, reject_threshold});
		lo = mor_pkg::wide_t'(sample) - mor_pkg::wide_t'({3'b000, reject_threshold});
		cnt_le = '0;
		cnt_ge = '0;
		for (int i = 0; i < mor_pkg::WINDOW; i++) begin
			le[i]  = mor_pkg::wide_t'(win[i]) <= hi;
			ge[i]  = mor_pkg::wide_t'(win[i]) >= lo;
			cnt_le = cnt_le + mor_pkg::CNT_W'(le[i]);
			cnt_ge = cnt_ge + mor_pkg::CNT_W'(ge[i]);
		end
		inside_band = (cnt_le >= mor_pkg::CNT_W'(mor_pkg::NEED_LE)) &&
			(cnt_ge >= mor_pkg::CNT_W'(mor_pkg::NEED_GE));
		sentinel = (sample == mor_pkg::SENT_ZERO) || (sample == mor_pkg::SENT_ONE) ||
			(sample == mor_pkg::SENT_TWO);
		verdict.rejected = filter_enable && !inside_band;
		verdict.store    = !(filter_enable && sentinel);
	end

endmodule

// ===== sv/median_outlier_reject_filter.sv =====
// Top level of the median outlier rejection filter.

// The block takes one signed Q16.16 sensor sample per item and returns one
// result item per sample, in order. With filtering off every sample passes.
// With filtering on, a sample passes only if it lies within reject_threshold
// of the median of the last five samples written to the window (the window
// as it stood before this sample); a passing sample becomes the held value,
// and a rejected one leaves the held value as it was and raises the rejected
// flag. The result always carries the held value. Every sample is written to
// the window, except that while filtering is on the readings 0.0, 1.0 and 2.0
// are skipped. Rate: one item per clock cycle, sustained while the result
// stream is not stalled by m_tready. An accepted item sits in the input
// register, and the window rank test and the held-value update resolve from
// there into the output register. The median is not sorted out explicitly;
// the sample's band edges are compared against all window entries in
// parallel and the counts decide, so this rank test sets the cycle time.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the block
// is idle; index 0 is filter_enable, index 1 is reject_threshold.
module median_outlier_reject_filter (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value_out
	output logic        m_tuser,   // [0] rejected
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_wdata
);

	// Configuration registers.
	logic             filter_enable_q;
	mor_pkg::thresh_t reject_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q    <= 1'b0;
			reject_threshold_q <= mor_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (mor_pkg::cfg_index_t'(cfg_index))
				mor_pkg::CFG_FILTER_ENABLE: begin
					filter_enable_q <= cfg_wdata[0];
				end
				mor_pkg::CFG_REJECT_THRESHOLD: begin
					reject_threshold_q <= cfg_wdata;
				end
			endcase
		end
	end

	// Handshake: the input register moves into the output register whenever
	// the output register is empty or being drained this cycle.
	logic             s1_vld_q;
	mor_pkg::sample_t sample_s1;
	logic             out_vld_q;
	logic             out_free;
	logic             advance;

	assign out_free = !out_vld_q || m_tready;
	assign advance  = s1_vld_q && out_free;
	assign s_tready = !s1_vld_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_tready) begin
			s1_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
		end
	end

	// Window ring and the verdict on the sample in the input register.
	mor_pkg::sample_t  win [mor_pkg::WINDOW];
	mor_pkg::verdict_t verdict;

	mor_judge u_judge (
		.sample           (sample_s1),
		.win              (win),
		.filter_enable    (filter_enable_q),
		.reject_threshold (reject_threshold_q),
		.verdict          (verdict)
	);

	mor_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance && verdict.store),
		.wr_data (sample_s1),
		.win     (win)
	);

	// Held value and output register.
	mor_pkg::sample_t held_q;
	mor_pkg::sample_t value_q;
	logic             rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance && !verdict.rejected) begin
				held_q <= sample_s1;
			end
			if (out_free) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q <= verdict.rejected ? held_q : sample_s1;
			rej_q   <= verdict.rejected;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = value_q;
	assign m_tuser  = rej_q;

	// A waiting result always carries the current held value.
	a_out_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (value_q == held_q))
		else $error("result value differs from held value");

	// A passing sample shows up unchanged in the next result.
	a_pass_value: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !verdict.rejected) |=> (value_q == $past(sample_s1)))
		else $error("passing sample not forwarded");

	// Nothing is rejected while filtering is off.
	a_reject_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && verdict.rejected) |-> filter_enable_q)
		else $error("rejection with filter disabled");

endmodule
